// ===== rtl/ptc_pkg.sv =====
// shared types, register codes and constants for the pressure and temperature compensation block
package ptc_pkg;

  // output scaling
  localparam int unsigned OUT_FRAC_BITS = 8;
  localparam int unsigned OUT_SH        = 16 - OUT_FRAC_BITS;
  localparam logic signed [63:0] OUT_HALF =
    (OUT_SH == 0) ? 64'sd0 : (64'sd1 <<< (OUT_SH - 1));

  // rounding offsets for the fixed shifts
  localparam logic signed [63:0] HALF_40 = 64'sd1 <<< 39;
  localparam logic signed [63:0] HALF_16 = 64'sd1 <<< 15;

  // clip limits
  localparam logic signed [63:0] PRESS_MAX = (64'sd1 <<< 31) - 64'sd1;
  localparam logic signed [63:0] PRESS_MIN = -(64'sd1 <<< 31);
  localparam logic signed [63:0] TEMP_MAX  = (64'sd1 <<< 23) - 64'sd1;
  localparam logic signed [63:0] TEMP_MIN  = -(64'sd1 <<< 23);

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RECIP_W    = 39;

  // rounded reciprocals 2^56 / k of the oversampling scale factors
  localparam logic [RECIP_W-1:0] SCALE_RECIP [8] = '{
    39'd137438953472,  // k = 524288
    39'd45812984491,   // k = 1572864
    39'd19634136210,   // k = 3670016
    39'd9162596898,    // k = 7864320
    39'd283744936200,  // k = 253952
    39'd139620524162,  // k = 516096
    39'd69260574978,   // k = 1040384
    39'd34494482440    // k = 2088960
  };

  typedef enum logic [2:0] {
    REG_TEMP_PAIR    = 3'd0,
    REG_OFFSET       = 3'd1,
    REG_LINEAR       = 3'd2,
    REG_TEMP_CROSS   = 3'd3,
    REG_SQUARE       = 3'd4,
    REG_SQUARE_TEMP  = 3'd5,
    REG_CUBE         = 3'd6,
    REG_RATE_SELECTS = 3'd7
  } reg_idx_e;

  typedef logic signed [23:0] raw_t;
  typedef logic signed [31:0] press_t;
  typedef logic signed [23:0] temp_t;
  typedef logic signed [22:0] scaled_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
    logic [2:0]         p_sel;
    logic [2:0]         t_sel;
  } coef_t;

endpackage

// ===== rtl/ptc_if.sv =====
// channel interfaces: raw samples in, compensated results out, register writes
interface ptc_in_if import ptc_pkg::*; ();
  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_out_if import ptc_pkg::*; ();
  logic   valid;
  logic   ready;
  press_t pressure_value;
  temp_t  temperature_value;
  logic   saturated;

  modport source (output valid, pressure_value, temperature_value, saturated, input ready);
  modport sink (input valid, pressure_value, temperature_value, saturated, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ptc_regs.sv =====
// coefficient and rate select registers with field decode
module ptc_regs import ptc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptc_cfg_if.sink       cfg_if,
  output coef_t         coef_o
);

  logic [23:0] temp_pair_q;
  logic [19:0] offset_q;
  logic [19:0] linear_q;
  logic [31:0] temp_cross_q;
  logic [15:0] square_q;
  logic [15:0] square_temp_q;
  logic [15:0] cube_q;
  logic [5:0]  rate_sel_q;

  logic wr;

  assign cfg_if.ready = 1'b1;
  assign wr = cfg_if.valid & cfg_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_pair_q   <= '0;
      offset_q      <= '0;
      linear_q      <= '0;
      temp_cross_q  <= '0;
      square_q      <= '0;
      square_temp_q <= '0;
      cube_q        <= '0;
      rate_sel_q    <= '0;
    end else if (wr) begin
      // bits above a register's width are dropped
      case (reg_idx_e'(cfg_if.index))
        REG_TEMP_PAIR:    temp_pair_q   <= cfg_if.data[23:0];
        REG_OFFSET:       offset_q      <= cfg_if.data[19:0];
        REG_LINEAR:       linear_q      <= cfg_if.data[19:0];
        REG_TEMP_CROSS:   temp_cross_q  <= cfg_if.data[31:0];
        REG_SQUARE:       square_q      <= cfg_if.data[15:0];
        REG_SQUARE_TEMP:  square_temp_q <= cfg_if.data[15:0];
        REG_CUBE:         cube_q        <= cfg_if.data[15:0];
        REG_RATE_SELECTS: rate_sel_q    <= cfg_if.data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef_o.c0    = $signed(temp_pair_q[23:12]);
    coef_o.c1    = $signed(temp_pair_q[11:0]);
    coef_o.c00   = $signed(offset_q);
    coef_o.c10   = $signed(linear_q);
    coef_o.c01   = $signed(temp_cross_q[31:16]);
    coef_o.c11   = $signed(temp_cross_q[15:0]);
    coef_o.c20   = $signed(square_q);
    coef_o.c21   = $signed(square_temp_q);
    coef_o.c30   = $signed(cube_q);
    coef_o.p_sel = rate_sel_q[5:3];
    coef_o.t_sel = rate_sel_q[2:0];
  end

endmodule

// ===== rtl/pressure_temp_compensation.sv =====
// pressure and temperature compensation top level: eight-stage multiply pipeline
//
//  channel     dir  handshake          payload
//  sample_if   in   valid / ready      raw_pressure, raw_temperature (s24 each)
//  result_if   out  valid / ready      pressure_value (s32), temperature_value (s24), saturated
//  cfg_if      in   valid / ready      index (3 bit), data (32 bit)
//
// one beat accepted every cycle while no held result stalls the stages; each result leaves the stage 8 register
// the pipeline depth follows the dependent multiply chain ps -> h1 -> ps*h1 -> h2 -> ps*h2
// reset clears all stage valid bits and the coefficient registers to zero
// a held result freezes every stage at once, so bubbles and beats keep their place
// register writes are always ready and take effect on the next cycle
module pressure_temp_compensation import ptc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptc_in_if.sink     sample_if,
  ptc_out_if.source  result_if,
  ptc_cfg_if.sink    cfg_if
);

  localparam int unsigned NUM_STAGES = 8;

  coef_t coef;

  ptc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .coef_o (coef)
  );

  logic [NUM_STAGES-1:0] vld_q;
  logic                  adv;

  assign adv             = ~vld_q[NUM_STAGES-1] | result_if.ready;
  assign sample_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], sample_if.valid};
    end
  end

  // stage 1: split reciprocal multiplies
  logic [RECIP_W-1:0] rp, rt;
  logic signed [44:0] s1_plo_d, s1_plo_q, s1_tlo_d, s1_tlo_q;
  logic signed [43:0] s1_phi_d, s1_phi_q, s1_thi_d, s1_thi_q;

  always_comb begin
    rp       = SCALE_RECIP[coef.p_sel];
    rt       = SCALE_RECIP[coef.t_sel];
    s1_plo_d = sample_if.raw_pressure * $signed({1'b0, rp[19:0]});
    s1_phi_d = sample_if.raw_pressure * $signed({1'b0, rp[38:20]});
    s1_tlo_d = sample_if.raw_temperature * $signed({1'b0, rt[19:0]});
    s1_thi_d = sample_if.raw_temperature * $signed({1'b0, rt[38:20]});
  end

  // stage 2: combine and round to q.16
  logic signed [63:0] p_full, t_full;
  scaled_t s2_ps_d, s2_ps_q, s2_ts_d, s2_ts_q;

  always_comb begin
    p_full  = (64'(s1_phi_q) <<< 20) + 64'(s1_plo_q) + HALF_40;
    t_full  = (64'(s1_thi_q) <<< 20) + 64'(s1_tlo_q) + HALF_40;
    s2_ps_d = p_full[62:40];
    s2_ts_d = t_full[62:40];
  end

  // stage 3: first-order terms
  logic signed [38:0] h1_full, g_full;
  logic signed [37:0] s3_h1_d, s3_h1_q, s3_g_d, s3_g_q;
  logic signed [38:0] s3_c_d, s3_c_q;
  logic signed [45:0] s3_tpr_d, s3_tpr_q;
  logic signed [34:0] s3_t_d, s3_t_q;
  scaled_t            s3_ps_q;

  always_comb begin
    h1_full  = (39'(coef.c20) <<< 16) + s2_ps_q * coef.c30;
    g_full   = (39'(coef.c11) <<< 16) + s2_ps_q * coef.c21;
    s3_h1_d  = h1_full[37:0];
    s3_g_d   = g_full[37:0];
    s3_c_d   = s2_ts_q * coef.c01;
    s3_tpr_d = s2_ts_q * s2_ps_q;
    s3_t_d   = (35'(coef.c0) <<< 15) + coef.c1 * s2_ts_q;
  end

  // stage 4: ps*h1 partials, round ts*ps, finish temperature
  logic signed [42:0] s4_ha_d, s4_ha_q;
  logic signed [41:0] s4_hb_d, s4_hb_q;
  logic signed [46:0] tp_sum;
  logic signed [27:0] s4_tp_d, s4_tp_q;
  logic signed [63:0] t_rnd;
  temp_t              s4_temp_d, s4_temp_q;
  logic               s4_tsat_d, s4_tsat_q;
  logic signed [37:0] s4_g_q;
  logic signed [38:0] s4_c_q;
  scaled_t            s4_ps_q;

  always_comb begin
    s4_ha_d = s3_ps_q * $signed({1'b0, s3_h1_q[18:0]});
    s4_hb_d = s3_ps_q * $signed(s3_h1_q[37:19]);
    tp_sum  = 47'(s3_tpr_q) + 47'(HALF_16);
    s4_tp_d = tp_sum[43:16];
    t_rnd   = (64'(s3_t_q) + OUT_HALF) >>> OUT_SH;
    if (t_rnd > TEMP_MAX) begin
      s4_temp_d = TEMP_MAX[23:0];
      s4_tsat_d = 1'b1;
    end else if (t_rnd < TEMP_MIN) begin
      s4_temp_d = TEMP_MIN[23:0];
      s4_tsat_d = 1'b1;
    end else begin
      s4_temp_d = t_rnd[23:0];
      s4_tsat_d = 1'b0;
    end
  end

  // stage 5: h2 and tp*g partials
  logic signed [63:0] ph1, h2_full;
  logic signed [42:0] s5_h2_d, s5_h2_q;
  logic signed [47:0] s5_da_d, s5_da_q;
  logic signed [46:0] s5_db_d, s5_db_q;
  logic signed [38:0] s5_c_q;
  scaled_t            s5_ps_q;
  temp_t              s5_temp_q;
  logic               s5_tsat_q;

  always_comb begin
    ph1     = (64'(s4_hb_q) <<< 19) + 64'(s4_ha_q) + HALF_16;
    h2_full = (ph1 >>> 16) + (64'(coef.c10) <<< 16);
    s5_h2_d = h2_full[42:0];
    s5_da_d = s4_tp_q * $signed({1'b0, s4_g_q[18:0]});
    s5_db_d = s4_tp_q * $signed(s4_g_q[37:19]);
  end

  // stage 6: ps*h2 partials, finish the cross term d
  logic signed [45:0] s6_ba_d, s6_ba_q;
  logic signed [43:0] s6_bb_d, s6_bb_q;
  logic signed [63:0] d_full;
  logic signed [47:0] s6_d_d, s6_d_q;
  logic signed [38:0] s6_c_q;
  temp_t              s6_temp_q;
  logic               s6_tsat_q;

  always_comb begin
    s6_ba_d = s5_ps_q * $signed({1'b0, s5_h2_q[21:0]});
    s6_bb_d = s5_ps_q * $signed(s5_h2_q[42:22]);
    d_full  = (64'(s5_db_q) <<< 19) + 64'(s5_da_q) + HALF_16;
    s6_d_d  = d_full[63:16];
  end

  // stage 7: b and the remaining sum
  logic signed [63:0] b_full;
  logic signed [47:0] s7_b_d, s7_b_q;
  logic signed [48:0] s7_acc_d, s7_acc_q;
  temp_t              s7_temp_q;
  logic               s7_tsat_q;

  always_comb begin
    b_full   = (64'(s6_bb_q) <<< 22) + 64'(s6_ba_q) + HALF_16;
    s7_b_d   = b_full[63:16];
    s7_acc_d = (49'(coef.c00) <<< 16) + 49'(s6_c_q) + 49'(s6_d_q);
  end

  // stage 8: pressure round and clip into the output register
  logic signed [63:0] p_sum, p_rnd;
  press_t             s8_press_d, s8_press_q;
  logic               s8_psat_d;
  logic               s8_sat_q;
  temp_t              s8_temp_q;

  always_comb begin
    p_sum = 64'(s7_acc_q) + 64'(s7_b_q);
    p_rnd = (p_sum + OUT_HALF) >>> OUT_SH;
    if (p_rnd > PRESS_MAX) begin
      s8_press_d = PRESS_MAX[31:0];
      s8_psat_d  = 1'b1;
    end else if (p_rnd < PRESS_MIN) begin
      s8_press_d = PRESS_MIN[31:0];
      s8_psat_d  = 1'b1;
    end else begin
      s8_press_d = p_rnd[31:0];
      s8_psat_d  = 1'b0;
    end
  end

  // payload registers, frozen together with the valid bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_plo_q   <= s1_plo_d;
      s1_phi_q   <= s1_phi_d;
      s1_tlo_q   <= s1_tlo_d;
      s1_thi_q   <= s1_thi_d;

      s2_ps_q    <= s2_ps_d;
      s2_ts_q    <= s2_ts_d;

      s3_h1_q    <= s3_h1_d;
      s3_g_q     <= s3_g_d;
      s3_c_q     <= s3_c_d;
      s3_tpr_q   <= s3_tpr_d;
      s3_t_q     <= s3_t_d;
      s3_ps_q    <= s2_ps_q;

      s4_ha_q    <= s4_ha_d;
      s4_hb_q    <= s4_hb_d;
      s4_tp_q    <= s4_tp_d;
      s4_temp_q  <= s4_temp_d;
      s4_tsat_q  <= s4_tsat_d;
      s4_g_q     <= s3_g_q;
      s4_c_q     <= s3_c_q;
      s4_ps_q    <= s3_ps_q;

      s5_h2_q    <= s5_h2_d;
      s5_da_q    <= s5_da_d;
      s5_db_q    <= s5_db_d;
      s5_c_q     <= s4_c_q;
      s5_ps_q    <= s4_ps_q;
      s5_temp_q  <= s4_temp_q;
      s5_tsat_q  <= s4_tsat_q;

      s6_ba_q    <= s6_ba_d;
      s6_bb_q    <= s6_bb_d;
      s6_d_q     <= s6_d_d;
      s6_c_q     <= s5_c_q;
      s6_temp_q  <= s5_temp_q;
      s6_tsat_q  <= s5_tsat_q;

      s7_b_q     <= s7_b_d;
      s7_acc_q   <= s7_acc_d;
      s7_temp_q  <= s6_temp_q;
      s7_tsat_q  <= s6_tsat_q;

      s8_press_q <= s8_press_d;
      s8_temp_q  <= s7_temp_q;
      s8_sat_q   <= s8_psat_d | s7_tsat_q;
    end
  end

  assign result_if.valid             = vld_q[NUM_STAGES-1];
  assign result_if.pressure_value    = s8_press_q;
  assign result_if.temperature_value = s8_temp_q;
  assign result_if.saturated         = s8_sat_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_if.valid && !result_if.ready |-> !sample_if.ready)
    else $error("input taken while result held");

  a_beat_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_if.valid && sample_if.ready |=> vld_q[0])
    else $error("accepted beat missing from first stage");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("stage valids moved during stall");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_if.valid && result_if.saturated |->
      (result_if.pressure_value == PRESS_MAX[31:0]) ||
      (result_if.pressure_value == PRESS_MIN[31:0]) ||
      (result_if.temperature_value == TEMP_MAX[23:0]) ||
      (result_if.temperature_value == TEMP_MIN[23:0]))
    else $error("saturated flag without a clipped result");

endmodule

// ===== tb/sv/pressure_temp_compensation_tb.sv =====
// self-checking testbench for the pressure and temperature compensation pipeline
`timescale 1ns / 100ps

module pressure_temp_compensation_tb;
  import ptc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned REPORT_CAP  = 30;
  localparam raw_t RAW_MAX = 24'sh7FFFFF;
  localparam raw_t RAW_MIN = 24'sh800000;

  // oversampling scale factors, one per rate index
  localparam longint unsigned SCALE_K [8] = '{
    64'd524288, 64'd1572864, 64'd3670016, 64'd7864320,
    64'd253952, 64'd516096, 64'd1040384, 64'd2088960
  };
  localparam int unsigned REG_BITS [8] = '{24, 20, 20, 32, 16, 16, 16, 6};

  typedef struct {
    press_t pressure;
    temp_t  temperature;
    logic   sat;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptc_in_if  sample_ch ();
  ptc_out_if result_ch ();
  ptc_cfg_if cfg_ch ();

  pressure_temp_compensation dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_if (sample_ch),
    .result_if (result_ch),
    .cfg_if    (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] coef_regs [8];
  reading_t    expected_readings [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  bit          sending = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor

  function automatic longint round_shift(longint v, int unsigned s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint scale_raw(raw_t raw, logic [2:0] idx);
    longint recip;
    recip = longint'(((64'd1 << 56) + SCALE_K[idx] / 2) / SCALE_K[idx]);
    return round_shift(longint'(raw) * recip, 40);
  endfunction

  function automatic reading_t compensate(raw_t p_raw, raw_t t_raw);
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint ps, ts, h1, h2, b, c, g, d, p, t;
    reading_t r;
    c0  = longint'($signed(coef_regs[REG_TEMP_PAIR][23:12]));
    c1  = longint'($signed(coef_regs[REG_TEMP_PAIR][11:0]));
    c00 = longint'($signed(coef_regs[REG_OFFSET][19:0]));
    c10 = longint'($signed(coef_regs[REG_LINEAR][19:0]));
    c01 = longint'($signed(coef_regs[REG_TEMP_CROSS][31:16]));
    c11 = longint'($signed(coef_regs[REG_TEMP_CROSS][15:0]));
    c20 = longint'($signed(coef_regs[REG_SQUARE][15:0]));
    c21 = longint'($signed(coef_regs[REG_SQUARE_TEMP][15:0]));
    c30 = longint'($signed(coef_regs[REG_CUBE][15:0]));
    ps  = scale_raw(p_raw, coef_regs[REG_RATE_SELECTS][5:3]);
    ts  = scale_raw(t_raw, coef_regs[REG_RATE_SELECTS][2:0]);

    h1 = c20 * 65536 + ps * c30;
    h2 = c10 * 65536 + round_shift(ps * h1, 16);
    b  = round_shift(ps * h2, 16);
    c  = ts * c01;
    g  = c11 * 65536 + ps * c21;
    d  = round_shift(round_shift(ts * ps, 16) * g, 16);
    p  = round_shift(c00 * 65536 + b + c + d, OUT_SH);
    t  = round_shift(c0 * 32768 + c1 * ts, OUT_SH);

    r.sat = 1'b0;
    if (p > PRESS_MAX) begin
      p = PRESS_MAX;
      r.sat = 1'b1;
    end else if (p < PRESS_MIN) begin
      p = PRESS_MIN;
      r.sat = 1'b1;
    end
    if (t > TEMP_MAX) begin
      t = TEMP_MAX;
      r.sat = 1'b1;
    end else if (t < TEMP_MIN) begin
      t = TEMP_MIN;
      r.sat = 1'b1;
    end
    r.pressure    = press_t'(p);
    r.temperature = temp_t'(t);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers

  function automatic int unsigned pause_len(bit enable);
    int unsigned roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic raw_t pick_raw();
    case ($urandom_range(0, 9))
      0: return RAW_MAX;
      1: return RAW_MIN;
      2: return raw_t'(int'($urandom_range(0, 511)) - 256);
      default: return raw_t'($urandom());
    endcase
  endfunction

  // field value of width w: extremes, zero or random
  function automatic logic [31:0] pick_field(int unsigned w);
    logic [31:0] span;
    span = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    case ($urandom_range(0, 5))
      0: return span >> 1;
      1: return (span >> 1) + 32'd1;
      2: return 32'd0;
      default: return $urandom() & span;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers

  task automatic stop_sending();
    if (sending) begin
      sample_ch.valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic send_sample(raw_t p_raw, raw_t t_raw);
    sample_ch.valid           <= 1'b1;
    sample_ch.raw_pressure    <= p_raw;
    sample_ch.raw_temperature <= t_raw;
    sending = 1'b1;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    expected_readings.push_back(compensate(p_raw, t_raw));
    @(negedge clk_i);
  endtask

  task automatic send_and_rest(raw_t p_raw, raw_t t_raw);
    int unsigned gap;
    send_sample(p_raw, t_raw);
    gap = pause_len(tx_gaps);
    if (gap != 0) begin
      stop_sending();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_readings.size() != 0) @(negedge clk_i);
  endtask

  // writes every register in turn; the block must be idle
  task automatic write_settings(input logic [31:0] vals [8]);
    reg_idx_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= r;
      cfg_ch.data  <= vals[r];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      coef_regs[r] = (REG_BITS[r] >= 32) ? vals[r]
                     : (vals[r] & ((32'd1 << REG_BITS[r]) - 32'd1));
      @(negedge clk_i);
      r = r.next();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_corner_set();
    raw_t p_set [5];
    raw_t t_set [5];
    p_set = '{RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN, 24'sd0};
    t_set = '{RAW_MAX, RAW_MIN, RAW_MIN, RAW_MAX, 24'sd0};
    foreach (p_set[i]) send_and_rest(p_set[i], t_set[i]);
  endtask

  // ---------------------------------------------------------------------------
  // result checking

  task automatic report_mismatch(string what, logic signed [63:0] want_v,
                                 logic signed [63:0] got_v);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result beat, expected none, actual pressure %0d temperature %0d",
                   $time, result_ch.pressure_value, result_ch.temperature_value);
      end else begin
        want = expected_readings.pop_front();
        if (result_ch.pressure_value !== want.pressure)
          report_mismatch("pressure_value", want.pressure, result_ch.pressure_value);
        if (result_ch.temperature_value !== want.temperature)
          report_mismatch("temperature_value", want.temperature,
                          result_ch.temperature_value);
        if (result_ch.saturated !== want.sat)
          report_mismatch("saturated", {63'd0, want.sat}, {63'd0, result_ch.saturated});
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = pause_len(rx_stalls);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL pressure_temp_compensation");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests

  // registers still at zero after reset, so every reading is zero
  task automatic test_reset_state();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_and_rest(24'sd0, 24'sd0);
    send_and_rest(RAW_MAX, RAW_MIN);
    send_and_rest(RAW_MIN, RAW_MAX);
    wait_drained();
  endtask

  // full-scale coefficients and samples, driving both results into clipping
  task automatic test_corners();
    logic [31:0] vals [8];
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;

    vals[REG_TEMP_PAIR]    = {8'h00, 12'h7FF, 12'h7FF};
    vals[REG_OFFSET]       = 32'h0007_FFFF;
    vals[REG_LINEAR]       = 32'h0007_FFFF;
    vals[REG_TEMP_CROSS]   = {16'h7FFF, 16'h7FFF};
    vals[REG_SQUARE]       = 32'h0000_7FFF;
    vals[REG_SQUARE_TEMP]  = 32'h0000_7FFF;
    vals[REG_CUBE]         = 32'h0000_7FFF;
    vals[REG_RATE_SELECTS] = {26'd0, 3'd4, 3'd4};
    write_settings(vals);
    send_corner_set();
    wait_drained();

    vals[REG_TEMP_PAIR]    = {8'h00, 12'h800, 12'h800};
    vals[REG_OFFSET]       = 32'h0008_0000;
    vals[REG_LINEAR]       = 32'h0008_0000;
    vals[REG_TEMP_CROSS]   = {16'h8000, 16'h8000};
    vals[REG_SQUARE]       = 32'h0000_8000;
    vals[REG_SQUARE_TEMP]  = 32'h0000_8000;
    vals[REG_CUBE]         = 32'h0000_8000;
    vals[REG_RATE_SELECTS] = {26'd0, 3'd3, 3'd0};
    write_settings(vals);
    send_corner_set();
    wait_drained();

    // data wider than every register but the 32-bit temp cross one: the high bits must be dropped
    foreach (vals[i]) vals[i] = 32'hFFFF_FFFF;
    write_settings(vals);
    send_and_rest(RAW_MAX, RAW_MIN);
    send_and_rest(24'sd1, -24'sd1);
    send_and_rest(RAW_MIN, RAW_MAX);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [31:0] vals [8];
    logic [31:0] hi_f, lo_f;
    reg_idx_e r;
    repeat (14) begin
      hi_f = pick_field(12);
      lo_f = pick_field(12);
      vals[REG_TEMP_PAIR] = (hi_f << 12) | lo_f;
      vals[REG_OFFSET]    = pick_field(20);
      vals[REG_LINEAR]    = pick_field(20);
      hi_f = pick_field(16);
      lo_f = pick_field(16);
      vals[REG_TEMP_CROSS]   = (hi_f << 16) | lo_f;
      vals[REG_SQUARE]       = pick_field(16);
      vals[REG_SQUARE_TEMP]  = pick_field(16);
      vals[REG_CUBE]         = pick_field(16);
      vals[REG_RATE_SELECTS] = pick_field(6);
      // junk above the width of registers narrower than 32 bits, added at random
      r = r.first();
      repeat (r.num()) begin
        if ($urandom_range(0, 1) != 0) vals[r] = vals[r] | ($urandom() << REG_BITS[r]);
        r = r.next();
      end
      write_settings(vals);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      repeat (55) send_and_rest(pick_raw(), pick_raw());
      wait_drained();
    end
  endtask

  // sender holds off until the pipeline has emptied, under heavy stalls
  task automatic test_drain_pause();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    repeat (6) begin
      repeat (8) send_and_rest(pick_raw(), pick_raw());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni                    = 1'b0;
    sample_ch.valid           = 1'b0;
    sample_ch.raw_pressure    = '0;
    sample_ch.raw_temperature = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_TEMP_PAIR;
    cfg_ch.data               = '0;
    foreach (coef_regs[i]) coef_regs[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_corners();
    test_random_settings();
    test_drain_pause();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS pressure_temp_compensation");
    end else begin
      $display("FAIL pressure_temp_compensation");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptc_pkg.sv
rtl/ptc_if.sv
rtl/ptc_regs.sv
rtl/pressure_temp_compensation.sv
tb/sv/pressure_temp_compensation_tb.sv
